FILE: design/bauc_pkg.sv
`default_nettype none
package bauc_pkg;

   // counter and hold count widths
   localparam int COUNT_WIDTH = 8;
   localparam int HOLD_WIDTH  = 16;

   // fixed widths of the interface fields and registers
   localparam int VALUE_WIDTH  = 8;
   localparam int TICKS_WIDTH  = 16;
   localparam int PERIOD_WIDTH = 8;
   localparam int CSR_WIDTH    = 16;

   // widths used to line up mixed-width values before a compare or a select
   localparam int CMP_WIDTH = (HOLD_WIDTH > TICKS_WIDTH) ? HOLD_WIDTH : TICKS_WIDTH;
   localparam int EXT_WIDTH = (COUNT_WIDTH > VALUE_WIDTH) ? COUNT_WIDTH : VALUE_WIDTH;

   localparam logic [HOLD_WIDTH-1:0]   HOLD_MAX = '1;
   localparam logic [PERIOD_WIDTH-1:0] REP_MAX  = '1;

   localparam logic [TICKS_WIDTH-1:0]  SLOW_HOLD_RESET   = 16'd100;
   localparam logic [TICKS_WIDTH-1:0]  FAST_HOLD_RESET   = 16'd300;
   localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RESET = 8'd50;
   localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RESET = 8'd10;

   typedef enum logic [1:0] {
      CSR_SLOW_HOLD   = 2'd0,
      CSR_FAST_HOLD   = 2'd1,
      CSR_SLOW_PERIOD = 2'd2,
      CSR_FAST_PERIOD = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_UP_FIRST  = 3'd1,
      MODE_UP_SLOW   = 3'd2,
      MODE_UP_FAST   = 3'd3,
      MODE_DN_FIRST  = 3'd4,
      MODE_DN_SLOW   = 3'd5,
      MODE_DN_FAST   = 3'd6
   } mode_type;

   typedef struct packed {
      logic [TICKS_WIDTH-1:0]  slow_hold_ticks;
      logic [TICKS_WIDTH-1:0]  fast_hold_ticks;
      logic [PERIOD_WIDTH-1:0] slow_period;
      logic [PERIOD_WIDTH-1:0] fast_period;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] counter_value;
      mode_type               mode;
      logic                   stepped;
   } result_type;

endpackage
`default_nettype wire

FILE: design/button_autorepeat_updown_counter.sv
// button auto-repeat up/down counter
//
// req channel: one word per 10 ms tick, carrying the raw active-low levels
// of the up and down buttons (req_up_raw, req_down_raw). a button counts as
// pressed when two consecutive samples are low; up wins over down.
// rsp channel: one word per req word, giving the counter after the tick,
// the repeat mode (idle, first, slow, fast per direction) and a step flag.
// csr port: write-only, csr_index picks slow hold, fast hold, slow period
// or fast period; write only while no tick is in flight.
//
// flow: an accepted word is registered in the input stage, then processed
// into the output register, from which it leaves while rsp_stall is low.
// throughput: one word per cycle while rsp_stall is low; the input
// stage and the output register form a two-deep pipeline, so a new word
// is taken while a result waits. when rsp_stall is high the output word
// holds, the input stage fills and then req_stall rises; nothing is dropped.
// reset (synchronous, active high) empties both stages, releases both
// buttons, clears hold and repeat counts and the counter, and loads the
// register defaults (100, 300, 50, 10 ticks).
`default_nettype none
module button_autorepeat_updown_counter (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic                             req_up_raw,
   input  wire logic                             req_down_raw,

   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [bauc_pkg::VALUE_WIDTH-1:0] rsp_counter_value,
   output      logic [2:0]                       rsp_mode,
   output      logic                             rsp_stepped,

   input  wire logic                             csr_write,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [bauc_pkg::CSR_WIDTH-1:0]   csr_data
);

   // input stage
   logic in_valid_ff, in_valid_in;
   logic up_ff;
   logic down_ff;

   // output stage
   logic                 rsp_valid_ff, rsp_valid_in;
   bauc_pkg::result_type rsp_ff;

   logic                 out_load;
   logic                 fire;
   logic                 req_take;
   bauc_pkg::cfg_type    cfg;
   bauc_pkg::result_type result;

   bauc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (bauc_pkg::csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bauc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .up_raw   (up_ff),
      .down_raw (down_ff),
      .cfg      (cfg),
      .result   (result)
   );

   // output register free when empty or being drained this cycle
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = out_load ? fire : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         up_ff   <= req_up_raw;
         down_ff <= req_down_raw;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_ff.counter_value;
   assign rsp_mode          = rsp_ff.mode;
   assign rsp_stepped       = rsp_ff.stepped;

   // every processed tick lands in the output register
   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word did not reach output register");

   // the input stage never stalls while the output register is free
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room downstream");

   // an idle word never reports a step
   a_idle_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.mode == bauc_pkg::MODE_IDLE) |-> !rsp_ff.stepped)
      else $error("step reported while idle");

endmodule
`default_nettype wire

FILE: design/bauc_csr.sv
`default_nettype none
module bauc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire bauc_pkg::csr_index_type        csr_index,
   input  wire logic [bauc_pkg::CSR_WIDTH-1:0] csr_data,
   output bauc_pkg::cfg_type                   cfg
);

   bauc_pkg::cfg_type cfg_ff;
   bauc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            bauc_pkg::CSR_SLOW_HOLD:
               cfg_in.slow_hold_ticks = csr_data[bauc_pkg::TICKS_WIDTH-1:0];
            bauc_pkg::CSR_FAST_HOLD:
               cfg_in.fast_hold_ticks = csr_data[bauc_pkg::TICKS_WIDTH-1:0];
            bauc_pkg::CSR_SLOW_PERIOD:
               cfg_in.slow_period = csr_data[bauc_pkg::PERIOD_WIDTH-1:0];
            bauc_pkg::CSR_FAST_PERIOD:
               cfg_in.fast_period = csr_data[bauc_pkg::PERIOD_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_hold_ticks <= bauc_pkg::SLOW_HOLD_RESET;
         cfg_ff.fast_hold_ticks <= bauc_pkg::FAST_HOLD_RESET;
         cfg_ff.slow_period     <= bauc_pkg::SLOW_PERIOD_RESET;
         cfg_ff.fast_period     <= bauc_pkg::FAST_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: design/bauc_core.sv
`default_nettype none
module bauc_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic               up_raw,
   input  wire logic               down_raw,
   input  wire bauc_pkg::cfg_type  cfg,
   output bauc_pkg::result_type    result
);

   logic                                prev_up_ff, prev_up_in;
   logic                                prev_down_ff, prev_down_in;
   logic [bauc_pkg::HOLD_WIDTH-1:0]     up_hold_ff, up_hold_in;
   logic [bauc_pkg::HOLD_WIDTH-1:0]     down_hold_ff, down_hold_in;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   slow_rep_ff, slow_rep_in;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   fast_rep_ff, fast_rep_in;
   logic [bauc_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                                up_pressed;
   logic                                down_pressed;
   logic [bauc_pkg::HOLD_WIDTH-1:0]     hold_cur;
   logic [bauc_pkg::HOLD_WIDTH-1:0]     hold_next;
   logic                                first_tick;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   slow_base;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   fast_base;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   slow_sat;
   logic [bauc_pkg::PERIOD_WIDTH-1:0]   fast_sat;
   logic                                in_fast;
   logic                                in_slow;
   logic                                step;
   logic [1:0]                          offset;
   logic [bauc_pkg::EXT_WIDTH-1:0]      count_ext;
   bauc_pkg::mode_type                  mode;

   assign up_pressed   = !prev_up_ff && !up_raw;
   assign down_pressed = !prev_down_ff && !down_raw;

   // shared hold path for whichever direction wins, up first
   assign hold_cur   = up_pressed ? up_hold_ff : down_hold_ff;
   assign first_tick = (hold_cur == '0);
   assign hold_next  = (hold_cur == bauc_pkg::HOLD_MAX) ? hold_cur
                     : hold_cur + bauc_pkg::HOLD_WIDTH'(1);
   assign slow_base  = first_tick ? '0 : slow_rep_ff;
   assign fast_base  = first_tick ? '0 : fast_rep_ff;
   assign slow_sat   = (slow_base == bauc_pkg::REP_MAX) ? slow_base
                     : slow_base + bauc_pkg::PERIOD_WIDTH'(1);
   assign fast_sat   = (fast_base == bauc_pkg::REP_MAX) ? fast_base
                     : fast_base + bauc_pkg::PERIOD_WIDTH'(1);
   assign in_fast    = bauc_pkg::CMP_WIDTH'(hold_next)
                       > bauc_pkg::CMP_WIDTH'(cfg.fast_hold_ticks);
   assign in_slow    = bauc_pkg::CMP_WIDTH'(hold_next)
                       > bauc_pkg::CMP_WIDTH'(cfg.slow_hold_ticks);

   always_comb begin
      prev_up_in   = up_raw;
      prev_down_in = down_raw;
      up_hold_in   = up_hold_ff;
      down_hold_in = down_hold_ff;
      slow_rep_in  = slow_base;
      fast_rep_in  = fast_base;
      count_in     = count_ff;
      step         = first_tick;
      offset       = 2'd1;

      // repeat timing for the held direction
      if (in_fast) begin
         offset = 2'd3;
         if (fast_sat >= cfg.fast_period) begin
            step        = 1'b1;
            fast_rep_in = '0;
         end else begin
            fast_rep_in = fast_sat;
         end
      end else if (in_slow) begin
         offset = 2'd2;
         if (slow_sat >= cfg.slow_period) begin
            step        = 1'b1;
            slow_rep_in = '0;
         end else begin
            slow_rep_in = slow_sat;
         end
      end

      if (up_pressed) begin
         up_hold_in   = hold_next;
         down_hold_in = '0;
         mode         = bauc_pkg::mode_type'({1'b0, offset});
         if (step) begin
            count_in = count_ff + bauc_pkg::COUNT_WIDTH'(1);
         end
      end else if (down_pressed) begin
         down_hold_in = hold_next;
         up_hold_in   = '0;
         mode         = bauc_pkg::mode_type'(3'd3 + {1'b0, offset});
         if (step) begin
            count_in = count_ff - bauc_pkg::COUNT_WIDTH'(1);
         end
      end else begin
         up_hold_in   = '0;
         down_hold_in = '0;
         slow_rep_in  = '0;
         fast_rep_in  = '0;
         step         = 1'b0;
         mode         = bauc_pkg::MODE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_up_ff   <= 1'b1;
         prev_down_ff <= 1'b1;
         up_hold_ff   <= '0;
         down_hold_ff <= '0;
         slow_rep_ff  <= '0;
         fast_rep_ff  <= '0;
         count_ff     <= '0;
      end else if (fire) begin
         prev_up_ff   <= prev_up_in;
         prev_down_ff <= prev_down_in;
         up_hold_ff   <= up_hold_in;
         down_hold_ff <= down_hold_in;
         slow_rep_ff  <= slow_rep_in;
         fast_rep_ff  <= fast_rep_in;
         count_ff     <= count_in;
      end
   end

   assign count_ext            = bauc_pkg::EXT_WIDTH'(count_in);
   assign result.counter_value = count_ext[bauc_pkg::VALUE_WIDTH-1:0];
   assign result.mode          = mode;
   assign result.stepped       = step;

   // state only moves on a processed tick
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff) && $stable(up_hold_ff) && $stable(down_hold_ff))
      else $error("core state changed without a tick");

   // a release tick clears both hold counts
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (result.mode == bauc_pkg::MODE_IDLE)
      |=> (up_hold_ff == '0) && (down_hold_ff == '0)
          && (slow_rep_ff == '0) && (fast_rep_ff == '0))
      else $error("hold state not cleared on release");

   // counter moves only on a stepped tick
   a_count_only_on_step: assert property (@(posedge clock) disable iff (reset)
      fire && !result.stepped |=> $stable(count_ff))
      else $error("counter changed without a step");

endmodule
`default_nettype wire

FILE: bench/button_autorepeat_updown_counter_test.sv
`timescale 1ns / 1ps

module button_autorepeat_updown_counter_test;

   // predicts the counter word for every accepted tick and checks the rsp side
   class autorepeat_board;
      typedef enum {PACE_FIRST, PACE_SLOW, PACE_FAST} pace_type;

      bauc_pkg::cfg_type                     cfg;
      bit                                    prev_up;
      bit                                    prev_dn;
      logic [bauc_pkg::HOLD_WIDTH-1:0]       up_hold;
      logic [bauc_pkg::HOLD_WIDTH-1:0]       dn_hold;
      logic [bauc_pkg::PERIOD_WIDTH-1:0]     slow_rep;
      logic [bauc_pkg::PERIOD_WIDTH-1:0]     fast_rep;
      logic [bauc_pkg::VALUE_WIDTH-1:0]      count;
      bauc_pkg::result_type                  predicted_words[$];
      int                                    faults;

      function new();
         cfg.slow_hold_ticks = bauc_pkg::SLOW_HOLD_RESET;
         cfg.fast_hold_ticks = bauc_pkg::FAST_HOLD_RESET;
         cfg.slow_period     = bauc_pkg::SLOW_PERIOD_RESET;
         cfg.fast_period     = bauc_pkg::FAST_PERIOD_RESET;
         prev_up  = 1'b1;
         prev_dn  = 1'b1;
         up_hold  = '0;
         dn_hold  = '0;
         slow_rep = '0;
         fast_rep = '0;
         count    = '0;
         faults   = 0;
      endfunction

      function void load_reg(bauc_pkg::csr_index_type idx,
                             logic [bauc_pkg::CSR_WIDTH-1:0] data);
         case (idx)
            bauc_pkg::CSR_SLOW_HOLD:   cfg.slow_hold_ticks = data;
            bauc_pkg::CSR_FAST_HOLD:   cfg.fast_hold_ticks = data;
            bauc_pkg::CSR_SLOW_PERIOD:
               cfg.slow_period = data[bauc_pkg::PERIOD_WIDTH-1:0];
            bauc_pkg::CSR_FAST_PERIOD:
               cfg.fast_period = data[bauc_pkg::PERIOD_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(bit up_raw, bit dn_raw);
         logic [bauc_pkg::HOLD_WIDTH-1:0] hold;
         pace_type                        pace;
         bit                              up_on;
         bit                              dn_on;
         bit                              moved;
         bauc_pkg::result_type            word;
         up_on = !prev_up && !up_raw;
         dn_on = !prev_dn && !dn_raw;
         prev_up = up_raw;
         prev_dn = dn_raw;
         moved = 1'b0;
         word.mode = bauc_pkg::MODE_IDLE;
         if (up_on || dn_on) begin
            // up wins; the other direction's hold starts over
            if (up_on) begin
               hold = up_hold;
               dn_hold = '0;
            end else begin
               hold = dn_hold;
               up_hold = '0;
            end
            if (hold == '0) begin
               slow_rep = '0;
               fast_rep = '0;
               moved = 1'b1;
            end
            if (hold != bauc_pkg::HOLD_MAX) hold = hold + 1'b1;
            // fast test first, whatever the threshold order
            if (hold > cfg.fast_hold_ticks) begin
               pace = PACE_FAST;
               if (fast_rep != bauc_pkg::REP_MAX) fast_rep = fast_rep + 1'b1;
               if (fast_rep >= cfg.fast_period) begin
                  moved = 1'b1;
                  fast_rep = '0;
               end
            end else if (hold > cfg.slow_hold_ticks) begin
               pace = PACE_SLOW;
               if (slow_rep != bauc_pkg::REP_MAX) slow_rep = slow_rep + 1'b1;
               if (slow_rep >= cfg.slow_period) begin
                  moved = 1'b1;
                  slow_rep = '0;
               end
            end else begin
               pace = PACE_FIRST;
            end
            if (up_on) begin
               up_hold = hold;
               if (moved) count = count + 1'b1;
               case (pace)
                  PACE_FAST: word.mode = bauc_pkg::MODE_UP_FAST;
                  PACE_SLOW: word.mode = bauc_pkg::MODE_UP_SLOW;
                  default:   word.mode = bauc_pkg::MODE_UP_FIRST;
               endcase
            end else begin
               dn_hold = hold;
               if (moved) count = count - 1'b1;
               case (pace)
                  PACE_FAST: word.mode = bauc_pkg::MODE_DN_FAST;
                  PACE_SLOW: word.mode = bauc_pkg::MODE_DN_SLOW;
                  default:   word.mode = bauc_pkg::MODE_DN_FIRST;
               endcase
            end
         end else begin
            up_hold  = '0;
            dn_hold  = '0;
            slow_rep = '0;
            fast_rep = '0;
         end
         word.counter_value = count;
         word.stepped = moved;
         predicted_words.push_back(word);
      endfunction

      function void check_word(logic [bauc_pkg::VALUE_WIDTH-1:0] value, logic [2:0] mode,
                               logic stepped);
         bauc_pkg::result_type want;
         if (predicted_words.size() == 0) begin
            $error("rsp word with nothing predicted: counter_value %0d mode %0d stepped %0d",
                   value, mode, stepped);
            faults++;
            return;
         end
         want = predicted_words.pop_front();
         if (value !== want.counter_value) begin
            $error("counter_value: expected %0d, got %0d", want.counter_value, value);
            faults++;
         end
         if (mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, mode);
            faults++;
         end
         if (stepped !== want.stepped) begin
            $error("stepped: expected %0d, got %0d", want.stepped, stepped);
            faults++;
         end
      endfunction

      function int pending();
         return predicted_words.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_up_raw;
   logic                             req_down_raw;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [bauc_pkg::VALUE_WIDTH-1:0] rsp_counter_value;
   logic [2:0]                       rsp_mode;
   logic                             rsp_stepped;
   logic                             csr_write;
   logic [1:0]                       csr_index;
   logic [bauc_pkg::CSR_WIDTH-1:0]   csr_data;

   autorepeat_board board = new();
   bit              quiet = 1'b0;   // no idling on either side while set
   int              ticks_sent = 0;

   button_autorepeat_updown_counter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_up_raw        (req_up_raw),
      .req_down_raw      (req_down_raw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_counter_value (rsp_counter_value),
      .rsp_mode          (rsp_mode),
      .rsp_stepped       (rsp_stepped),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // both handshakes sampled at the rising edge, before any register moves
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_tick(req_up_raw, req_down_raw);
         if (rsp_valid && !rsp_stall)
            board.check_word(rsp_counter_value, rsp_mode, rsp_stepped);
      end
   end

   // receiver back-pressure: random stall bursts between free stretches
   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 30)) @(negedge clock);
         if (!quiet && $urandom_range(0, 1) != 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // one tick word; entered and left at a falling edge, valid left high
   task automatic send_tick(bit up_raw, bit dn_raw);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         // sender gap
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_up_raw   <= up_raw;
      req_down_raw <= dn_raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // hold one button low for a number of ticks, the other released
   task automatic hold_button(bit go_up, int len);
      repeat (len) send_tick(!go_up, go_up);
   endtask

   // stop sending and let every predicted word come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // all four registers, written back to back while the block is empty
   task automatic write_setting(logic [bauc_pkg::TICKS_WIDTH-1:0] slow_hold,
                                logic [bauc_pkg::TICKS_WIDTH-1:0] fast_hold,
                                logic [bauc_pkg::PERIOD_WIDTH-1:0] slow_per,
                                logic [bauc_pkg::PERIOD_WIDTH-1:0] fast_per);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= bauc_pkg::CSR_SLOW_HOLD;
      csr_data  <= slow_hold;
      board.load_reg(bauc_pkg::CSR_SLOW_HOLD, slow_hold);
      @(negedge clock);
      csr_index <= bauc_pkg::CSR_FAST_HOLD;
      csr_data  <= fast_hold;
      board.load_reg(bauc_pkg::CSR_FAST_HOLD, fast_hold);
      @(negedge clock);
      csr_index <= bauc_pkg::CSR_SLOW_PERIOD;
      csr_data  <= bauc_pkg::CSR_WIDTH'(slow_per);
      board.load_reg(bauc_pkg::CSR_SLOW_PERIOD, bauc_pkg::CSR_WIDTH'(slow_per));
      @(negedge clock);
      csr_index <= bauc_pkg::CSR_FAST_PERIOD;
      csr_data  <= bauc_pkg::CSR_WIDTH'(fast_per);
      board.load_reg(bauc_pkg::CSR_FAST_PERIOD, bauc_pkg::CSR_WIDTH'(fast_per));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // random presses: mostly clean holds with random lengths, some direction
   // swaps and both-pressed stretches, and a little raw noise
   task automatic run_presses(int budget, int span);
      int  stop_at;
      int  kind;
      int  len;
      int  len2;
      bit  go_up;
      stop_at = ticks_sent + budget;
      while (ticks_sent < stop_at) begin
         kind  = $urandom_range(0, 9);
         go_up = 1'($urandom_range(0, 1));
         // short holds are cheap; long ones reach slow and fast repeat
         len   = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12)
                                             : $urandom_range(1, span);
         len2  = $urandom_range(1, 20);
         repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b1);
         if (kind <= 4) begin
            hold_button(go_up, len);
         end else if (kind == 5) begin
            // both low, then up lets go and down takes over
            repeat (len) send_tick(1'b0, 1'b0);
            hold_button(1'b0, len2);
         end else if (kind <= 7) begin
            hold_button(go_up, len);
            hold_button(!go_up, len2);
         end else begin
            repeat ($urandom_range(1, 8))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_up_raw   = 1'b1;
      req_down_raw = 1'b1;
      csr_write    = 1'b0;
      csr_index    = bauc_pkg::CSR_SLOW_HOLD;
      csr_data     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset defaults
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);                 // one low sample is no press
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);                 // first press steps up
      send_tick(1'b0, 1'b1);                 // held, no step
      send_tick(1'b0, 1'b0);                 // both low, up wins
      send_tick(1'b1, 1'b0);                 // up let go, down takes over at once
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);                 // up low again but only one sample
      send_tick(1'b0, 1'b0);                 // up pressed, swap back
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);                 // down press to zero
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);                 // wraps below zero
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);                 // wraps back above the top
      send_tick(1'b1, 1'b1);

      // random part, walking through several register settings
      run_presses(320, 340);
      write_setting(16'd3, 16'd8, 8'd2, 8'd1);
      run_presses(260, 20);
      write_setting(16'd1, 16'd1, 8'd1, 8'd1);     // every register set to one
      run_presses(220, 12);
      write_setting(16'd10, 16'd4, 8'd3, 8'd255);  // fast threshold below slow
      run_presses(260, 400);
      write_setting(16'd0, 16'd0, 8'd0, 8'd0);     // zero threshold and period
      run_presses(160, 8);
      write_setting(16'd65534, 16'd65535, 8'd255, 8'd255);
      run_presses(140, 400);

      // last part without idling on either side
      wait_drained();
      quiet = 1'b1;
      write_setting(16'd5, 16'd20, 8'd4, 8'd2);
      run_presses(300, 40);

      wait_drained();
      repeat (8) @(negedge clock);
      if (board.faults == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
